// ----- rtl/core/msb_pkg.sv -----
// ----------------------------------------------------------------------------
// msb_pkg
// Shared types and constants for the meter segment brightness block.
// ----------------------------------------------------------------------------
`default_nettype none

package msb_pkg;

   // Default widths for the top-level parameters
   localparam int LEVEL_BITS_DEF = 17;
   localparam int FRAC_BITS_DEF  = 15;

   // Fixed field widths
   localparam int RANGE_BITS     = 14;
   localparam int BRIGHT_BITS    = 16;
   localparam int FACTOR_BITS    = 16;
   localparam int CSR_INDEX_BITS = 3;

   // Reset values of the control registers
   localparam int LOWER_RESET = -36864;
   localparam int RANGE_RESET = 256;

   // Register map
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LOWER   = 3'd0,
      CSR_RANGE   = 3'd1,
      CSR_TOPMOST = 3'd2,
      CSR_RETAIN  = 3'd3,
      CSR_NEWF    = 3'd4
   } csr_index_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIVIDE,
      ST_MUL_OLD,
      ST_MUL_NEW,
      ST_COMMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic classify;
      logic div_step;
      logic mul_old;
      logic mul_new;
      logic commit;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic need_div;
      logic need_fade;
      logic out_free;
   } dp_status_type;

endpackage : msb_pkg

`default_nettype wire

// ----- rtl/core/msb_if.sv -----
// ----------------------------------------------------------------------------
// msb_req_if / msb_rsp_if
// Valid/ready channels carrying the level beat in and the brightness beat out.
// ----------------------------------------------------------------------------
`default_nettype none

interface msb_req_if #(
   parameter int LEVEL_BITS = 17
);
   logic                         valid;
   logic                         ready;
   logic signed [LEVEL_BITS-1:0] normal_level;
   logic signed [LEVEL_BITS-1:0] normal_peak;
   logic signed [LEVEL_BITS-1:0] discrete_level;
   logic signed [LEVEL_BITS-1:0] discrete_peak;

   modport source (
      output valid, normal_level, normal_peak, discrete_level, discrete_peak,
      input  ready
   );
   modport sink (
      input  valid, normal_level, normal_peak, discrete_level, discrete_peak,
      output ready
   );
endinterface : msb_req_if

interface msb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] brightness;
   logic        peak_marker;
   logic        changed;

   modport source (
      output valid, brightness, peak_marker, changed,
      input  ready
   );
   modport sink (
      input  valid, brightness, peak_marker, changed,
      output ready
   );
endinterface : msb_rsp_if

`default_nettype wire

// ----- rtl/core/meter_segment_brightness.sv -----
// ----------------------------------------------------------------------------
// meter_segment_brightness
// Brightness and peak marker for one segment of a level meter bar.
//
//   channel  | direction | payload
//   ---------+-----------+------------------------------------------------
//   req_ch   | in        | normal_level, normal_peak, discrete_level,
//            |           | discrete_peak (signed Q8.8 dB)
//   rsp_ch   | out       | brightness (Q1.15), peak_marker, changed
//   csr_*    | in        | csr_we, csr_index, csr_wdata (write only)
//
// A beat is loaded, classified and committed; the division and the fade add
// their own states in between: the restoring divider resolves one quotient
// bit per cycle, and the fade uses one multiplier for two products.
// One beat is in work at a time; a finished result waits in the output
// register while the next beat is accepted. A stalled rsp_ch holds the commit.
// Reset is synchronous; it loads the control registers with their reset values and clears the segment state.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_segment_brightness
   import msb_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   localparam int CSR_W     = (LEVEL_BITS > FACTOR_BITS) ? LEVEL_BITS : FACTOR_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   msb_req_if.sink                   req_ch,
   msb_rsp_if.source                 rsp_ch,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_W-1:0]          csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   msb_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   msb_datapath #(
      .LEVEL_BITS (LEVEL_BITS),
      .FRAC_BITS  (FRAC_BITS),
      .CSR_W      (CSR_W)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .status         (status),
      .normal_level   (req_ch.normal_level),
      .normal_peak    (req_ch.normal_peak),
      .discrete_level (req_ch.discrete_level),
      .discrete_peak  (req_ch.discrete_peak),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .brightness     (rsp_ch.brightness),
      .peak_marker    (rsp_ch.peak_marker),
      .changed        (rsp_ch.changed)
   );

endmodule : meter_segment_brightness

`default_nettype wire

// ----- rtl/core/msb_ctrl.sv -----
// ----------------------------------------------------------------------------
// msb_ctrl
// Sequencer: accept a beat, classify, run the divider and the fade
// multiplies when they apply, then commit the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_ctrl
   import msb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   localparam int CNT_W = $clog2(FRAC_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAC_BITS - 1);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cmd.classify = 1'b1;
            cnt_in       = CNT_LAST;
            if (status.need_div) begin
               state_in = ST_DIVIDE;
            end else if (status.need_fade) begin
               state_in = ST_MUL_OLD;
            end else begin
               state_in = ST_COMMIT;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = status.need_fade ? ST_MUL_OLD : ST_COMMIT;
            end
         end
         ST_MUL_OLD: begin
            cmd.mul_old = 1'b1;
            state_in    = ST_MUL_NEW;
         end
         ST_MUL_NEW: begin
            cmd.mul_new = 1'b1;
            state_in    = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : msb_ctrl

`default_nettype wire

// ----- rtl/core/msb_datapath.sv -----
// ----------------------------------------------------------------------------
// msb_datapath
// Control registers, threshold tests, restoring divider, fade multiply and
// the output register with the segment state.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_datapath
   import msb_pkg::*;
#(
   parameter int LEVEL_BITS = LEVEL_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int CSR_W      = 17
) (
   input  logic                         clock,
   input  logic                         reset,
   // control register writes
   input  logic                         csr_we,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_W-1:0]             csr_wdata,
   // sequencing
   input  ctrl_cmd_type                 cmd,
   output dp_status_type                status,
   // input beat
   input  logic signed [LEVEL_BITS-1:0] normal_level,
   input  logic signed [LEVEL_BITS-1:0] normal_peak,
   input  logic signed [LEVEL_BITS-1:0] discrete_level,
   input  logic signed [LEVEL_BITS-1:0] discrete_peak,
   // output beat
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [BRIGHT_BITS-1:0]       brightness,
   output logic                         peak_marker,
   output logic                         changed
);

   localparam int BW     = FRAC_BITS + 1;
   localparam int CMP_W  = ((LEVEL_BITS > RANGE_BITS + 1) ? LEVEL_BITS : RANGE_BITS + 1) + 1;
   localparam int PROD_W = BW + FACTOR_BITS;
   localparam int ACC_W  = PROD_W + 1;
   localparam int SHR_W  = ACC_W - FRAC_BITS;
   localparam logic [BW-1:0] ONE        = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [BW-1:0] FADE_FLOOR = BW'((33 * (1 << FRAC_BITS)) >> 15);

   // Control registers
   logic signed [LEVEL_BITS-1:0] lower_ff;
   logic [RANGE_BITS-1:0]        range_ff;
   logic                         topmost_ff;
   logic [FACTOR_BITS-1:0]       retain_ff;
   logic [FACTOR_BITS-1:0]       newf_ff;

   // Segment state
   logic [BW-1:0]                bright_ff, bright_in;
   logic                         marker_ff;

   // Latched input beat
   logic signed [LEVEL_BITS-1:0] normal_ff, npeak_ff, discrete_ff, dpeak_ff;

   // Work registers
   logic [BW-1:0]                b_ff;
   logic                         m_ff;
   logic [RANGE_BITS:0]          rem_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic [ACC_W-1:0]             acc_ff;

   // Output register
   logic                         rsp_valid_ff;
   logic [BRIGHT_BITS-1:0]       brightness_ff;
   logic                         peak_marker_ff;
   logic                         changed_ff;

   // Threshold tests on the latched beat
   logic signed [CMP_W-1:0] lower_x, upper_x, normal_x, npeak_x, discrete_x, dpeak_x, diff_x;
   logic                    fade, ge_upper, below, disc_in, np_in, dp_in, mark;
   logic [BW-1:0]           b_sel;
   logic                    div_sel;

   always_comb begin
      lower_x    = CMP_W'(lower_ff);
      upper_x    = lower_x + $signed({{(CMP_W - RANGE_BITS){1'b0}}, range_ff});
      normal_x   = CMP_W'(normal_ff);
      npeak_x    = CMP_W'(npeak_ff);
      discrete_x = CMP_W'(discrete_ff);
      dpeak_x    = CMP_W'(dpeak_ff);
      diff_x     = normal_x - lower_x;
      fade       = (retain_ff != '0);
      ge_upper   = (normal_x >= upper_x);
      below      = (normal_x < lower_x);
      disc_in    = (discrete_x >= lower_x) && (discrete_x < upper_x);
      np_in      = (npeak_x >= lower_x) && (npeak_x < upper_x);
      dp_in      = (dpeak_x >= lower_x) && (dpeak_x < upper_x);
      div_sel    = 1'b0;
      if (ge_upper) begin
         b_sel = (fade && !topmost_ff) ? '0 : ONE;
      end else if (disc_in) begin
         b_sel = ONE;
      end else if (below) begin
         b_sel = '0;
      end else if (fade) begin
         b_sel = ONE;
      end else begin
         b_sel   = '0;
         div_sel = (range_ff != '0);
      end
      if (topmost_ff) begin
         mark = (npeak_x >= lower_x) || (dpeak_x >= lower_x);
      end else begin
         mark = np_in || dp_in;
      end
   end

   assign status.need_div  = div_sel;
   assign status.need_fade = fade && (bright_ff > FADE_FLOOR);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Divider step: shift remainder, subtract range when it fits
   logic [RANGE_BITS:0] rem_shl;
   logic                rem_ge;

   always_comb begin
      rem_shl = {rem_ff[RANGE_BITS-1:0], 1'b0};
      rem_ge  = (rem_shl >= {1'b0, range_ff});
   end

   // Share one multiplier between the two fade products
   logic [BW-1:0]          mul_a;
   logic [FACTOR_BITS-1:0] mul_b;
   logic [PROD_W-1:0]      mul_p;

   always_comb begin
      mul_a = cmd.mul_old ? bright_ff : b_ff;
      mul_b = cmd.mul_old ? retain_ff : newf_ff;
      mul_p = mul_a * mul_b;
   end

   // Final value: fade result saturated at one, or the selected or divided value
   logic [SHR_W-1:0] acc_shr;

   always_comb begin
      acc_shr = SHR_W'(acc_ff >> FRAC_BITS);
      if (!status.need_fade) begin
         bright_in = b_ff;
      end else if (acc_shr > SHR_W'(ONE)) begin
         bright_in = ONE;
      end else begin
         bright_in = acc_shr[BW-1:0];
      end
   end

   // Control registers and segment state
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff   <= LEVEL_BITS'(LOWER_RESET);
         range_ff   <= RANGE_BITS'(RANGE_RESET);
         topmost_ff <= 1'b0;
         retain_ff  <= '0;
         newf_ff    <= '0;
         bright_ff  <= '0;
         marker_ff  <= 1'b0;
      end else begin
         if (cmd.commit) begin
            bright_ff <= bright_in;
            marker_ff <= m_ff;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_LOWER: begin
                  lower_ff  <= csr_wdata[LEVEL_BITS-1:0];
                  marker_ff <= 1'b0;
               end
               CSR_RANGE: begin
                  range_ff  <= csr_wdata[RANGE_BITS-1:0];
                  marker_ff <= 1'b0;
               end
               CSR_TOPMOST: topmost_ff <= csr_wdata[0];
               CSR_RETAIN:  retain_ff  <= csr_wdata[FACTOR_BITS-1:0];
               CSR_NEWF:    newf_ff    <= csr_wdata[FACTOR_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Latch the beat, classify, divide, multiply
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         normal_ff   <= normal_level;
         npeak_ff    <= normal_peak;
         discrete_ff <= discrete_level;
         dpeak_ff    <= discrete_peak;
      end
      if (cmd.classify) begin
         b_ff   <= b_sel;
         m_ff   <= mark;
         rem_ff <= {1'b0, diff_x[RANGE_BITS-1:0]};
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? (rem_shl - {1'b0, range_ff}) : rem_shl;
         b_ff   <= {b_ff[BW-2:0], rem_ge};
      end
      if (cmd.mul_old) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_new) begin
         acc_ff <= ACC_W'(prod_ff) + ACC_W'(mul_p);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         brightness_ff  <= BRIGHT_BITS'(bright_in);
         peak_marker_ff <= m_ff;
         changed_ff     <= (bright_in != bright_ff) || (m_ff != marker_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign brightness  = brightness_ff;
   assign peak_marker = peak_marker_ff;
   assign changed     = changed_ff;

endmodule : msb_datapath

`default_nettype wire

// ----- rtl/core/msb_checker.sv -----
// ----------------------------------------------------------------------------
// msb_checker
// Port-level checks on the request and response channels.
// ----------------------------------------------------------------------------
`default_nettype none

module msb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] brightness,
   input logic        peak_marker,
   input logic        changed
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   // Keep the payload of a stalled response beat
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(brightness) && $stable(peak_marker) && $stable(changed))
      else $error("rsp payload moved while stalled");

   // Drop ready right after a request beat is taken
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

   // No response straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule : msb_checker

bind meter_segment_brightness msb_checker u_msb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .brightness  (rsp_ch.brightness),
   .peak_marker (rsp_ch.peak_marker),
   .changed     (rsp_ch.changed)
);

`default_nettype wire
